// File: hw/rtl/omst_pkg.sv
// shared types, codes and constants for the ordered multiset table
`default_nettype none

package omst_pkg;

  localparam int CAPACITY_DEF = 64;
  localparam int DATA_W       = 32;
  localparam int COUNT_W      = 7;

  // request kinds; codes 2 and 3 act as a membership test
  localparam logic [1:0] REQ_INSERT = 2'd0;
  localparam logic [1:0] REQ_REMOVE = 2'd1;

  // result status codes
  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_DUP  = 2'd1;
  localparam logic [1:0] ST_MISS = 2'd2;
  localparam logic [1:0] ST_FULL = 2'd3;

  // register select bit of the config address
  localparam logic REG_KEEP_SORTED = 1'b0;
  localparam logic REG_ALLOW_DUP   = 1'b1;

  typedef enum logic [1:0] {
    ENG_IDLE,
    ENG_SCAN,
    ENG_DONE
  } eng_state_t;

  typedef enum logic [1:0] {
    OP_INSERT,
    OP_DUPCHK,
    OP_REMOVE,
    OP_FIND
  } op_t;

  typedef struct packed {
    logic keep_sorted;
    logic allow_dup;
  } mode_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [COUNT_W-1:0] entry_count;
    logic               is_empty;
  } res_t;

endpackage

`default_nettype wire

// File: hw/rtl/omst_engine.sv
// entry memory and the scan / shift sequencer of the ordered multiset table
`default_nettype none

module omst_engine import omst_pkg::*; #(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  mode_t             mode,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [1:0]        req_type,
  input  logic [DATA_W-1:0] value,
  output logic              res_valid,
  input  logic              res_ready,
  output res_t              res
);

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);

  // entry memory, one read and one write port, registered read data
  logic [DATA_W-1:0] mem [CAPACITY];
  logic [DATA_W-1:0] rdata_r;
  logic              rd_en;
  logic [AW-1:0]     rd_addr;
  logic              wr_en;
  logic [AW-1:0]     wr_addr;
  logic [DATA_W-1:0] wr_data;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata_r <= mem[rd_addr];
    end
  end

  eng_state_t        state_r, state_nxt;
  op_t               op_r, op_nxt;
  logic [DATA_W-1:0] value_r, value_nxt;
  logic [DATA_W-1:0] carry_r, carry_nxt;
  logic              flag_r, flag_nxt;      // placing on insert, deleted on remove
  logic              stop_r, stop_nxt;      // ordered remove passed a larger entry
  logic [CW-1:0]     rd_idx_r, rd_idx_nxt;
  logic [CW-1:0]     wr_ptr_r, wr_ptr_nxt;
  logic              proc_valid_r;
  logic [AW-1:0]     proc_idx_r;
  logic [CW-1:0]     occ_r, occ_nxt;
  logic [1:0]        status_r, status_nxt;

  logic              eq;
  logic              gt;
  logic              full;
  logic              term;
  logic              del;
  logic [CW+COUNT_W-1:0] occ_ext;

  assign eq   = (rdata_r == value_r);
  assign gt   = ($signed(rdata_r) > $signed(value_r));
  assign full = (occ_r == CW'(CAPACITY));
  assign del  = eq && (mode.allow_dup ? !stop_r : !flag_r);

  always_comb begin
    state_nxt  = state_r;
    op_nxt     = op_r;
    value_nxt  = value_r;
    carry_nxt  = carry_r;
    flag_nxt   = flag_r;
    stop_nxt   = stop_r;
    rd_idx_nxt = rd_idx_r;
    wr_ptr_nxt = wr_ptr_r;
    occ_nxt    = occ_r;
    status_nxt = status_r;
    rd_en      = 1'b0;
    rd_addr    = rd_idx_r[AW-1:0];
    wr_en      = 1'b0;
    wr_addr    = proc_idx_r;
    wr_data    = carry_r;
    term       = 1'b0;
    in_ready   = 1'b0;
    res_valid  = 1'b0;

    unique case (state_r)
      ENG_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          value_nxt  = value;
          carry_nxt  = value;
          flag_nxt   = 1'b0;
          stop_nxt   = 1'b0;
          rd_idx_nxt = '0;
          wr_ptr_nxt = '0;
          state_nxt  = ENG_SCAN;
          unique case (req_type)
            REQ_INSERT: op_nxt = mode.keep_sorted ? OP_INSERT : OP_DUPCHK;
            REQ_REMOVE: op_nxt = OP_REMOVE;
            default:    op_nxt = OP_FIND;
          endcase
        end
      end

      ENG_SCAN: begin
        if (proc_valid_r) begin
          unique case (op_r)
            OP_FIND: begin
              if (eq) begin
                term       = 1'b1;
                status_nxt = ST_OK;
                state_nxt  = ENG_DONE;
              end
            end
            OP_DUPCHK: begin
              if (eq && !mode.allow_dup) begin
                term       = 1'b1;
                status_nxt = ST_DUP;
                state_nxt  = ENG_DONE;
              end
            end
            OP_INSERT: begin
              if (!flag_r && !mode.allow_dup && eq) begin
                term       = 1'b1;
                status_nxt = ST_DUP;
                state_nxt  = ENG_DONE;
              end else if (flag_r || gt) begin
                if (!flag_r && full) begin
                  term       = 1'b1;
                  status_nxt = ST_FULL;
                  state_nxt  = ENG_DONE;
                end else begin
                  // ripple the held word one place toward the back
                  wr_en     = 1'b1;
                  wr_addr   = proc_idx_r;
                  wr_data   = carry_r;
                  carry_nxt = rdata_r;
                  flag_nxt  = 1'b1;
                end
              end
            end
            OP_REMOVE: begin
              if (del) begin
                flag_nxt = 1'b1;
              end else begin
                // compact kept entries down to the write pointer
                wr_en      = 1'b1;
                wr_addr    = wr_ptr_r[AW-1:0];
                wr_data    = rdata_r;
                wr_ptr_nxt = wr_ptr_r + 1'b1;
              end
              if (mode.keep_sorted && gt) begin
                stop_nxt = 1'b1;
              end
            end
            default: ;
          endcase
        end

        if (!term && (rd_idx_r < occ_r)) begin
          rd_en      = 1'b1;
          rd_idx_nxt = rd_idx_r + 1'b1;
        end else if (!term && !proc_valid_r) begin
          // pass complete
          unique case (op_r)
            OP_FIND: begin
              status_nxt = ST_MISS;
              state_nxt  = ENG_DONE;
            end
            OP_DUPCHK: begin
              if (full) begin
                status_nxt = ST_FULL;
                state_nxt  = ENG_DONE;
              end else begin
                op_nxt     = OP_INSERT;
                flag_nxt   = 1'b1;
                carry_nxt  = value_r;
                rd_idx_nxt = '0;
              end
            end
            OP_INSERT: begin
              if (full) begin
                status_nxt = ST_FULL;
              end else begin
                wr_en      = 1'b1;
                wr_addr    = occ_r[AW-1:0];
                wr_data    = carry_r;
                occ_nxt    = occ_r + 1'b1;
                status_nxt = ST_OK;
              end
              state_nxt = ENG_DONE;
            end
            OP_REMOVE: begin
              occ_nxt    = wr_ptr_r;
              status_nxt = flag_r ? ST_OK : ST_MISS;
              state_nxt  = ENG_DONE;
            end
            default: ;
          endcase
        end
      end

      ENG_DONE: begin
        res_valid = 1'b1;
        if (res_ready) begin
          state_nxt = ENG_IDLE;
        end
      end

      default: state_nxt = ENG_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ENG_IDLE;
      occ_r        <= '0;
      proc_valid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      occ_r        <= occ_nxt;
      proc_valid_r <= rd_en;
    end
  end

  always_ff @(posedge clk) begin
    op_r       <= op_nxt;
    value_r    <= value_nxt;
    carry_r    <= carry_nxt;
    flag_r     <= flag_nxt;
    stop_r     <= stop_nxt;
    rd_idx_r   <= rd_idx_nxt;
    wr_ptr_r   <= wr_ptr_nxt;
    status_r   <= status_nxt;
    proc_idx_r <= rd_addr;
  end

  assign occ_ext         = {{COUNT_W{1'b0}}, occ_r};
  assign res.status      = status_r;
  assign res.entry_count = occ_ext[COUNT_W-1:0];
  assign res.is_empty    = (occ_r == '0);

endmodule

`default_nettype wire

// File: hw/rtl/ordered_multiset_table_top.sv
// top level of the ordered multiset table: config registers, engine, result register
//
//  channel  dir  ports                         word
//  in       in   in_tvalid/in_tready           tuser: req_type, tdata: value
//  out      out  out_tvalid/out_tready         tuser: status, tdata: entry_count, is_empty
//  cfg      in   cfg_psel/penable/pwrite/...   reg 0 keep_sorted @0, reg 1 allow_duplicates @4
//
// a request takes at most one pass over the stored entries; an unordered insert takes two
// passes, a duplicate check and then the insert (a full table ends after the first)
// the pass length is set by the single entry memory: one entry read and one written per cycle
// reset (rst_n low, synchronous) empties the table at once; no clearing pass
// a finished result waits in the output register while the next word is taken;
// the engine holds its result only when that register is still full
`default_nettype none

module ordered_multiset_table_top import omst_pkg::*; #(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // request stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,    // [31:0] value
  input  logic [1:0]  in_tuser,    // [1:0] req_type
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,   // [6:0] entry_count, [7] is_empty
  output logic [1:0]  out_tuser,   // [1:0] status
  // config port
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  // mode registers
  logic  keep_sorted_r, keep_sorted_nxt;
  logic  allow_dup_r, allow_dup_nxt;
  logic  cfg_wr;
  mode_t mode;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_comb begin
    keep_sorted_nxt = keep_sorted_r;
    allow_dup_nxt   = allow_dup_r;
    if (cfg_wr) begin
      // the select bit picks the register, low address bits are ignored
      unique case (cfg_paddr[2])
        REG_KEEP_SORTED: keep_sorted_nxt = cfg_pwdata[0];
        REG_ALLOW_DUP:   allow_dup_nxt   = cfg_pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_paddr[2])
      REG_KEEP_SORTED: cfg_prdata = {31'b0, keep_sorted_r};
      REG_ALLOW_DUP:   cfg_prdata = {31'b0, allow_dup_r};
      default:         cfg_prdata = '0;
    endcase
  end

  assign mode.keep_sorted = keep_sorted_r;
  assign mode.allow_dup   = allow_dup_r;

  // engine
  logic res_valid;
  logic res_ready;
  res_t res;

  omst_engine #(
    .CAPACITY (CAPACITY)
  ) u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .mode      (mode),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .req_type  (in_tuser),
    .value     (in_tdata),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  // output register, parts the engine from the result stream
  logic out_valid_r, out_valid_nxt;
  res_t out_res_r;
  logic load;

  assign res_ready = !out_valid_r || out_tready;
  assign load      = res_valid && res_ready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      keep_sorted_r <= 1'b1;
      allow_dup_r   <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      keep_sorted_r <= keep_sorted_nxt;
      allow_dup_r   <= allow_dup_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_res_r.status;
  assign out_tdata  = {out_res_r.is_empty, out_res_r.entry_count};

endmodule

`default_nettype wire

// File: sim/tb.sv
// testbench for ordered_multiset_table_top: random and directed requests checked against a predictor
`timescale 1ns / 1ps

module tb;
  import omst_pkg::*;

  // request kinds the package leaves unnamed; both act as a membership test
  localparam logic [1:0] REQ_FIND     = 2'd2;
  localparam logic [1:0] REQ_FIND_ALT = 2'd3;

  // register byte addresses
  localparam logic [2:0] ADDR_KEEP_SORTED = 3'd0;
  localparam logic [2:0] ADDR_ALLOW_DUP   = 3'd4;

  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int DRAIN_CYCLES = 2 * CAPACITY_DEF + 10;

  localparam logic signed [DATA_W-1:0] INT_MIN = 32'sh8000_0000;
  localparam logic signed [DATA_W-1:0] INT_MAX = 32'sh7fff_ffff;

  // how a random stretch leans: grow the table, shrink it, or hit stored values
  typedef enum int {
    MIX_FILL,
    MIX_DRAIN,
    MIX_KNOWN
  } mix_t;

  typedef struct packed {
    logic [1:0]        req;
    logic [DATA_W-1:0] value;
  } req_word_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata = '0;    // [31:0] value
  logic [1:0]  in_tuser = '0;    // [1:0] req_type
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [7:0]  out_tdata;        // [6:0] entry_count, [7] is_empty
  logic [1:0]  out_tuser;        // [1:0] status
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [2:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  // words waiting to be sent and results waiting to come back
  req_word_t pending_reqs[$];
  res_t      expected_results[$];

  // predictor state: held values front first, plus its copy of the mode registers
  logic signed [DATA_W-1:0] held_vals[$];
  logic                     model_sorted = 1'b1;
  logic                     model_dup    = 1'b0;

  // values sent as inserts, reused to hit stored entries
  logic signed [DATA_W-1:0] inserted_vals[$];
  logic signed [DATA_W-1:0] corner_vals[7] =
      '{INT_MIN, INT_MIN + 1, -1, 0, 1, INT_MAX - 1, INT_MAX};

  int send_idle_pct = 30;
  int recv_idle_pct = 56;
  int error_count = 0;
  int cycle_count = 0;

  ordered_multiset_table_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  always #5 clk = ~clk;

  // linear search over the held values
  function automatic bit table_holds(logic signed [DATA_W-1:0] v);
    foreach (held_vals[i])
      if (held_vals[i] == v) return 1'b1;
    return 1'b0;
  endfunction

  // apply one request to the predictor and return the result it should give
  function automatic res_t apply_request(logic [1:0] req, logic signed [DATA_W-1:0] v);
    res_t       r;
    logic [1:0] st;
    int         pos;
    st  = ST_OK;
    pos = 0;
    case (req)
      REQ_INSERT: begin
        if (!model_sorted) begin
          // front insert; duplicate check scans everything
          if (!model_dup && table_holds(v)) st = ST_DUP;
        end else begin
          // stop before the first larger entry, so equal values stay ahead
          while (pos < held_vals.size()) begin
            if (!model_dup && held_vals[pos] == v) begin
              st = ST_DUP;
              break;
            end
            if (held_vals[pos] > v) break;
            pos++;
          end
        end
        // a refused duplicate wins over a full table
        if (st == ST_OK) begin
          if (held_vals.size() >= CAPACITY_DEF) st = ST_FULL;
          else held_vals.insert(pos, v);
        end
      end
      REQ_REMOVE: begin
        st = ST_MISS;
        if (!model_dup) begin
          // first match only, whole table, order ignored
          foreach (held_vals[i])
            if (held_vals[i] == v) begin
              held_vals.delete(i);
              st = ST_OK;
              break;
            end
        end else begin
          // every match; ordered mode quits at the first larger entry
          while (pos < held_vals.size()) begin
            if (model_sorted && held_vals[pos] > v) break;
            if (held_vals[pos] == v) begin
              held_vals.delete(pos);
              st = ST_OK;
            end else begin
              pos++;
            end
          end
        end
      end
      default: st = table_holds(v) ? ST_OK : ST_MISS;
    endcase
    r.status      = st;
    r.entry_count = COUNT_W'(held_vals.size());
    r.is_empty    = (held_vals.size() == 0);
    return r;
  endfunction

  // driver: holds a word until taken, then maybe idles before the next one
  always @(posedge clk) begin
    req_word_t w;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready)
        expected_results.push_back(apply_request(in_tuser, $signed(in_tdata)));
      if (!in_tvalid || in_tready) begin
        if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          w = pending_reqs.pop_front();
          in_tvalid <= 1'b1;
          in_tuser  <= w.req;
          in_tdata  <= w.value;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // monitor: compare each taken result with the oldest prediction, then pick ready
  always @(posedge clk) begin
    res_t want;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (expected_results.size() == 0) begin
          $display("%0t: result with none expected: status %0d tdata %h",
                   $time, out_tuser, out_tdata);
          error_count++;
        end else begin
          want = expected_results.pop_front();
          if (out_tuser !== want.status) begin
            $display("%0t: status mismatch: expected %0d actual %0d",
                     $time, want.status, out_tuser);
            error_count++;
          end
          if (out_tdata[6:0] !== want.entry_count) begin
            $display("%0t: entry_count mismatch: expected %0d actual %0d",
                     $time, want.entry_count, out_tdata[6:0]);
            error_count++;
          end
          if (out_tdata[7] !== want.is_empty) begin
            $display("%0t: is_empty mismatch: expected %0d actual %0d",
                     $time, want.is_empty, out_tdata[7]);
            error_count++;
          end
        end
      end
      out_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  task automatic queue_request(logic [1:0] req, logic signed [DATA_W-1:0] v);
    req_word_t w;
    w.req   = req;
    w.value = v;
    pending_reqs.push_back(w);
    if (req == REQ_INSERT) inserted_vals.push_back(v);
  endtask

  // settle: nothing left to send, nothing outstanding (checked off the active edge)
  task automatic wait_drained();
    do @(negedge clk);
    while (pending_reqs.size() != 0 || in_tvalid || expected_results.size() != 0);
  endtask

  // register write with setup and access phases; the predictor follows once the write has landed
  task automatic write_reg(logic [2:0] addr, logic [31:0] data);
    @(posedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= addr;
    cfg_pwdata  <= data;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    if (addr == ADDR_KEEP_SORTED) model_sorted = data[0];
    else model_dup = data[0];
  endtask

  // mostly a narrow band so values collide, plus corners, reuse and full-range
  function automatic logic signed [DATA_W-1:0] pick_value(int reuse_pct);
    int r;
    r = $urandom_range(99);
    if (r < reuse_pct && inserted_vals.size() != 0)
      return inserted_vals[$urandom_range(inserted_vals.size() - 1)];
    r = $urandom_range(99);
    if (r < 55) return $signed($urandom_range(80)) - 40;
    if (r < 70) return corner_vals[$urandom_range(6)];
    return $signed($urandom);
  endfunction

  task automatic queue_random(int n, mix_t mix);
    int         r;
    logic [1:0] find_code;
    for (int k = 0; k < n; k++) begin
      r = $urandom_range(99);
      find_code = ($urandom_range(3) == 0) ? REQ_FIND_ALT : REQ_FIND;
      case (mix)
        MIX_FILL:
          if (r < 75) queue_request(REQ_INSERT, pick_value(15));
          else if (r < 87) queue_request(REQ_REMOVE, pick_value(50));
          else queue_request(find_code, pick_value(40));
        MIX_DRAIN:
          if (r < 15) queue_request(REQ_INSERT, pick_value(15));
          else if (r < 80) queue_request(REQ_REMOVE, pick_value(70));
          else queue_request(find_code, pick_value(50));
        default:
          if (r < 70) queue_request(REQ_INSERT, pick_value(100));
          else queue_request(find_code, pick_value(100));
      endcase
    end
  endtask

  // set both modes, send a random stretch, and let it finish before the next write
  task automatic run_phase(logic sorted, logic dup, int n, mix_t mix);
    write_reg(ADDR_KEEP_SORTED, {31'b0, sorted});
    write_reg(ADDR_ALLOW_DUP, {31'b0, dup});
    queue_random(n, mix);
    wait_drained();
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // sorted set, the reset modes, written explicitly
    write_reg(ADDR_KEEP_SORTED, 32'd1);
    write_reg(ADDR_ALLOW_DUP, 32'd0);
    queue_request(REQ_FIND, 0);            // lookup on an empty table
    queue_request(REQ_REMOVE, 0);          // remove on an empty table
    queue_request(REQ_INSERT, INT_MAX);
    queue_request(REQ_INSERT, INT_MIN);
    queue_request(REQ_INSERT, 0);
    queue_request(REQ_INSERT, -1);
    queue_request(REQ_INSERT, 1);
    queue_request(REQ_INSERT, 0);          // refused duplicate
    queue_request(REQ_FIND, INT_MIN);
    queue_request(REQ_FIND_ALT, 5);        // code 3 acts as a lookup
    queue_request(REQ_REMOVE, -1);
    queue_request(REQ_REMOVE, -1);
    wait_drained();

    // sorted multiset: remove takes every match and stops past the value
    write_reg(ADDR_ALLOW_DUP, 32'd1);
    queue_request(REQ_INSERT, 1);
    queue_request(REQ_INSERT, 1);
    queue_request(REQ_REMOVE, 1);
    queue_request(REQ_FIND, 1);
    wait_drained();

    // plain list: front inserts, remove takes every match across the table
    write_reg(ADDR_KEEP_SORTED, 32'd0);
    queue_request(REQ_INSERT, INT_MAX);
    queue_request(REQ_INSERT, INT_MAX);
    queue_request(REQ_REMOVE, INT_MAX);
    queue_request(REQ_INSERT, 3);
    wait_drained();

    // unordered set: duplicate check on the front-insert path
    write_reg(ADDR_ALLOW_DUP, 32'd0);
    queue_request(REQ_INSERT, 3);
    queue_request(REQ_INSERT, -7);
    queue_request(REQ_REMOVE, 3);
    wait_drained();

    // random stretches; the table carries over, so mode changes hit unsorted contents
    run_phase(1'b1, 1'b0, 60, MIX_FILL);
    run_phase(1'b0, 1'b0, 60, MIX_DRAIN);
    run_phase(1'b1, 1'b1, 80, MIX_FILL);   // should reach the capacity limit

    send_idle_pct = 56;
    recv_idle_pct = 30;
    run_phase(1'b1, 1'b0, 30, MIX_KNOWN);  // duplicates against a full table
    run_phase(1'b0, 1'b1, 70, MIX_DRAIN);
    run_phase(1'b0, 1'b1, 60, MIX_FILL);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_phase(1'b1, 1'b1, 70, MIX_DRAIN);
    run_phase(1'b0, 1'b0, 70, MIX_FILL);
    run_phase(1'b1, 1'b0, 60, MIX_DRAIN);

    // quiet tail to catch stray results
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0 && expected_results.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
